// ----- sv/gfau_pkg.sv -----
package gfau_pkg;

	localparam int unsigned FIELD_W = 8;

	typedef enum logic [1:0] {
		ACT_MUL = 2'd0,
		ACT_SQR = 2'd1,
		ACT_INV = 2'd2
	} action_t;

	// Two folding passes for x^8 = x^4 + x^3 + x^2 + 1 bring a 15-bit product back to a byte.
	function automatic logic [FIELD_W-1:0] gf_fold(input logic [2*FIELD_W-2:0] v);
		logic [10:0] w;
		logic [2:0]  h;
		w = {3'b0, v[7:0]} ^ {4'b0, v[14:8]} ^ {2'b0, v[14:8], 2'b0}
			^ {1'b0, v[14:8], 3'b0} ^ {v[14:8], 4'b0};
		h = w[10:8];
		return w[7:0] ^ {5'b0, h} ^ {3'b0, h, 2'b0} ^ {2'b0, h, 3'b0} ^ {1'b0, h, 4'b0};
	endfunction

	// Carry-less product of two bytes, then reduction.
	function automatic logic [FIELD_W-1:0] gf_mul(input logic [FIELD_W-1:0] x,
			input logic [FIELD_W-1:0] y);
		logic [2*FIELD_W-2:0] acc;
		acc = '0;
		for (int k = 0; k < FIELD_W; k++) begin
			if (y[k]) begin
				acc = acc ^ ({{(FIELD_W-1){1'b0}}, x} << k);
			end
		end
		return gf_fold(acc);
	endfunction

	// Squaring is linear: the bits move to the even positions before reduction.
	function automatic logic [FIELD_W-1:0] gf_sqr(input logic [FIELD_W-1:0] x);
		logic [2*FIELD_W-2:0] spread;
		spread = '0;
		for (int k = 0; k < FIELD_W; k++) begin
			spread[2*k] = x[k];
		end
		return gf_fold(spread);
	endfunction

endpackage

// ----- sv/gfau_inv_pipe.sv -----
module gfau_inv_pipe (
	input  logic                         clk,
	input  logic [gfau_pkg::FIELD_W-1:0] x_s1,
	output logic [gfau_pkg::FIELD_W-1:0] p127_s6
);
	import gfau_pkg::*;

	// One field multiply per stage; the squarings around it are plain XOR networks.
	logic [FIELD_W-1:0] p2;
	logic [FIELD_W-1:0] p3_s2, p4_s2;
	logic [FIELD_W-1:0] p4_s3, p7_s3;
	logic [FIELD_W-1:0] p4_s4, p7_s4, p11_s4;
	logic [FIELD_W-1:0] p7_s5, p15_s5;
	logic [FIELD_W-1:0] p120;

	assign p2   = gf_sqr(x_s1);
	assign p120 = gf_sqr(gf_sqr(gf_sqr(p15_s5)));

	always_ff @(posedge clk) begin
		p3_s2   <= gf_mul(p2, x_s1);
		p4_s2   <= gf_sqr(p2);
		p7_s3   <= gf_mul(p4_s2, p3_s2);
		p4_s3   <= p4_s2;
		p11_s4  <= gf_mul(p4_s3, p7_s3);
		p4_s4   <= p4_s3;
		p7_s4   <= p7_s3;
		p15_s5  <= gf_mul(p11_s4, p4_s4);
		p7_s5   <= p7_s4;
		p127_s6 <= gf_mul(p120, p7_s5);
	end

endmodule

// ----- sv/gf256_arithmetic_unit.sv -----
// A command transferred at one edge is registered in stage s1 and passes stages s2 to s6,
// then its result is on result from the output register, marked by the strobe done for one cycle;
// the depth is set by the inverse chain, one field multiply per stage.
// Throughput: one command per cycle; busy is never raised and the receiver cannot stall.
// Reset: arst_n low clears every valid bit at once, so no strobe follows reset
// until a new command is accepted; payload registers are not reset.
module gf256_arithmetic_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [gfau_pkg::FIELD_W-1:0] a,
	input  logic [gfau_pkg::FIELD_W-1:0] b,
	output logic [gfau_pkg::FIELD_W-1:0] result,
	output logic                         done
);
	import gfau_pkg::*;

	// Control and the early result of multiply or square travel together down the line.
	// The valid bits run alongside in their own reset registers.
	typedef struct packed {
		logic [1:0]         op;
		logic [FIELD_W-1:0] plain;
	} stage_t;

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [FIELD_W-1:0] a_s1;
	logic [FIELD_W-1:0] b_s1;
	logic [FIELD_W-1:0] plain_s1;
	logic               valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	stage_t             st_s2, st_s3, st_s4, st_s5, st_s6;
	logic [FIELD_W-1:0] p127_s6;
	logic [FIELD_W-1:0] final_s6;
	logic [FIELD_W-1:0] result_q;
	logic               done_q;

	// The pipeline never holds, so a command transfer can take place in every cycle.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= action;
		a_s1  <= a;
		b_s1  <= b;
	end

	// Multiply and square are done within the first stage; inverse needs the full chain.
	always_comb begin
		case (op_s1)
			ACT_MUL: plain_s1 = gf_mul(a_s1, b_s1);
			ACT_SQR: plain_s1 = gf_sqr(a_s1);
			default: plain_s1 = '0;
		endcase
	end

	gfau_inv_pipe u_inv (
		.clk     (clk),
		.x_s1    (a_s1),
		.p127_s6 (p127_s6)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		st_s2.op    <= op_s1;
		st_s2.plain <= plain_s1;
		st_s3.op    <= st_s2.op;
		st_s3.plain <= st_s2.plain;
		st_s4.op    <= st_s3.op;
		st_s4.plain <= st_s3.plain;
		st_s5.op    <= st_s4.op;
		st_s5.plain <= st_s4.plain;
		st_s6.op    <= st_s5.op;
		st_s6.plain <= st_s5.plain;
	end

	// The last squaring turns x^127 into x^254, the inverse; zero stays zero.
	always_comb begin
		case (st_s6.op)
			ACT_INV: final_s6 = gf_sqr(p127_s6);
			default: final_s6 = st_s6.plain;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= final_s6;
	end

	assign result = result_q;
	assign done   = done_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("accepted command produced no result after seven cycles");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result strobe without a matching command");

	a_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(action, 7) == ACT_MUL |-> result == gf_mul($past(a, 7), $past(b, 7)))
		else $error("multiply result wrong");

	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(action, 7) == ACT_INV |->
			(gf_mul(result, $past(a, 7)) == 8'd1) || ($past(a, 7) == 8'd0 && result == 8'd0))
		else $error("inverse result is not the field inverse");

	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(action, 7) != ACT_MUL && $past(action, 7) != ACT_SQR
			&& $past(action, 7) != ACT_INV |-> result == 8'd0)
		else $error("unused action code gave a non-zero result");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the GF(2^8) arithmetic unit (field polynomial 0x11D).
// Commands are queued up front by the stimulus process and handed to the unit by a
// clocked driver. The driver inserts random gaps at a rate that each command carries.
// Every accepted transfer predicts its result byte. A clocked monitor compares each
// strobed result with the oldest prediction still waiting.
module tb;

	import gfau_pkg::*;

	// Action code 3 has no operation behind it. The unit must answer it with zero.
	localparam logic [1:0] ACT_NONE = 2'd3;

	// The exponent that takes a field element to its inverse (x^254 = x^-1).
	localparam logic [7:0] INV_EXPONENT = 8'd254;

	// The low byte of the field polynomial, folded back in when bit 7 shifts out.
	localparam logic [7:0] POLY_LOW = 8'h1D;

	localparam int unsigned RANDOM_CMDS    = 400;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  a;
		logic [7:0]  b;
		int unsigned gap_pct;
	} field_cmd_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] value;
	} awaited_byte_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] action;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] result;
	logic       done;

	field_cmd_t    pending_cmds[$];
	awaited_byte_t awaited_bytes[$];
	field_cmd_t    next_cmd;
	awaited_byte_t oldest_byte;
	int unsigned   fail_count;
	int unsigned   quiet_cycles;

	gf256_arithmetic_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.action (action),
		.a      (a),
		.b      (b),
		.result (result),
		.done   (done)
	);

	// Shift-and-add multiply. The multiplicand is reduced on every shift, rather
	// than folding a wide product at the end. The field result is the same.
	function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] acc;
		logic [7:0] shifted;
		acc     = 8'h00;
		shifted = x;
		for (int k = 0; k < 8; k++) begin
			if (y[k]) begin
				acc = acc ^ shifted;
			end
			shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? POLY_LOW : 8'h00);
		end
		return acc;
	endfunction

	// Left-to-right square-and-multiply over the bits of 254. Zero stays at zero.
	function automatic logic [7:0] field_inverse(input logic [7:0] x);
		logic [7:0] acc;
		acc = 8'h01;
		for (int k = 7; k >= 0; k--) begin
			acc = field_product(acc, acc);
			if (INV_EXPONENT[k]) begin
				acc = field_product(acc, x);
			end
		end
		return acc;
	endfunction

	function automatic logic [7:0] field_outcome(input logic [1:0] op, input logic [7:0] x,
			input logic [7:0] y);
		case (op)
			ACT_MUL: begin
				return field_product(x, y);
			end
			ACT_SQR: begin
				return field_product(x, x);
			end
			ACT_INV: begin
				return field_inverse(x);
			end
			default: begin
				return 8'h00;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic queue_cmd(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
			input int unsigned gap_pct);
		field_cmd_t cmd;
		cmd.op      = op;
		cmd.a       = x;
		cmd.b       = y;
		cmd.gap_pct = gap_pct;
		pending_cmds.push_back(cmd);
	endtask

	// Random operands lean towards the edges of the field: zero, one and all ones.
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'h01;
			end
			2: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Driver. A transfer takes place at an edge where start is high and busy is low.
	// The prediction is taken there, from the values that were on the ports. The
	// driver then either presents the next command or idles. It idles with the
	// probability that the command at the head of the queue carries. While idle,
	// the operand ports carry noise, which the unit must ignore.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited_bytes.push_back('{op: action, a: a, b: b,
					value: field_outcome(action, a, b)});
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0
						&& $urandom_range(99) >= pending_cmds[0].gap_pct) begin
					next_cmd = pending_cmds.pop_front();
					start  <= 1'b1;
					action <= next_cmd.op;
					a      <= next_cmd.a;
					b      <= next_cmd.b;
				end else begin
					start  <= 1'b0;
					action <= 2'($urandom);
					a      <= 8'($urandom);
					b      <= 8'($urandom);
				end
			end
		end
	end

	// Monitor. A result is valid for exactly one cycle, so it is sampled at the edge
	// that closes that cycle. No back-pressure is possible from this side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("result strobe is unknown");
			end else if (done) begin
				if (awaited_bytes.size() == 0) begin
					report_mismatch($sformatf("result %02h with no command outstanding",
						result));
				end else begin
					oldest_byte = awaited_bytes.pop_front();
					if (result !== oldest_byte.value) begin
						report_mismatch($sformatf(
							"action %0d a %02h b %02h: result %02h, expected %02h",
							oldest_byte.op, oldest_byte.a, oldest_byte.b, result,
							oldest_byte.value));
					end
				end
			end
		end
	end

	// Watchdog. It counts the cycles in which neither side completes a transfer, and
	// gives up once the unit has clearly hung.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [1:0] op;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = 2'b00;
		a            = 8'h00;
		b            = 8'h00;
		fail_count   = 0;
		quiet_cycles = 0;

		// Directed commands go back to back. They cover zero operands on either side
		// of a multiply, and products that need both folding passes. They also cover
		// the square and inverse of the field edges, with b set to show it is ignored.
		// The unused action code comes last, with both operands at zero and at all ones.
		queue_cmd(ACT_MUL, 8'h00, 8'hFF, 0);
		queue_cmd(ACT_MUL, 8'hFF, 8'h00, 0);
		queue_cmd(ACT_MUL, 8'h01, 8'hFF, 0);
		queue_cmd(ACT_MUL, 8'hFF, 8'hFF, 0);
		queue_cmd(ACT_MUL, 8'h80, 8'h80, 0);
		queue_cmd(ACT_MUL, 8'h02, 8'h80, 0);
		queue_cmd(ACT_MUL, 8'h53, 8'hCA, 0);
		queue_cmd(ACT_SQR, 8'h00, 8'hFF, 0);
		queue_cmd(ACT_SQR, 8'h01, 8'h00, 0);
		queue_cmd(ACT_SQR, 8'h80, 8'h5A, 0);
		queue_cmd(ACT_SQR, 8'hFF, 8'hA5, 0);
		queue_cmd(ACT_INV, 8'h00, 8'hFF, 0);
		queue_cmd(ACT_INV, 8'h01, 8'h00, 0);
		queue_cmd(ACT_INV, 8'h02, 8'h33, 0);
		queue_cmd(ACT_INV, 8'h80, 8'hCC, 0);
		queue_cmd(ACT_INV, 8'hFF, 8'hFF, 0);
		queue_cmd(ACT_NONE, 8'hFF, 8'hFF, 0);
		queue_cmd(ACT_NONE, 8'h00, 8'h00, 0);

		// Random commands fall in four phases of sender behaviour: back to back, idle with a
		// probability of 58 percent, then of 21 percent, then back to back once more. The unused
		// action code turns up now and then, so that both bits of action toggle.
		for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
			if ($urandom_range(11) == 0) begin
				op = ACT_NONE;
			end else begin
				op = 2'($urandom_range(2));
			end
			case (n / (RANDOM_CMDS / 4))
				1: begin
					queue_cmd(op, pick_operand(), pick_operand(), 58);
				end
				2: begin
					queue_cmd(op, pick_operand(), pick_operand(), 21);
				end
				default: begin
					queue_cmd(op, pick_operand(), pick_operand(), 0);
				end
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// All stimulus has been accepted once the queue is empty and start has dropped.
		// After that, wait for the last results, then for DRAIN_CYCLES more beyond them
		// to catch any stray strobe.
		do begin
			@(posedge clk);
		end while (pending_cmds.size() > 0 || start);
		while (awaited_bytes.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_bytes.size() > 0) begin
			report_mismatch($sformatf("%0d results never arrived", awaited_bytes.size()));
		end
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
